@@ src/filter_runtime_tick_cascade_core_macros.svh @@
// Assertion macros shared by the checker of the tick cascade core.
`ifndef FILTER_RUNTIME_TICK_CASCADE_CORE_MACROS_SVH
`define FILTER_RUNTIME_TICK_CASCADE_CORE_MACROS_SVH

// Checked at every rising edge while reset is released.
`define FRTC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, including during reset.
`define FRTC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/frtc_pkg.sv @@
package frtc_pkg;

    localparam int FINE_DIVIDE_DEFAULT = 10;
    localparam int COARSE_WRAP_DEFAULT = 1080;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 13;

    localparam logic [CFG_INDEX_W-1:0] REG_TICKS_PER_SUB        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SUBS_PER_MINUTE      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MINUTES_PER_HOUR     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HOURS_PER_BLOCK      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCKS_FOR_CHANGE    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_TICKS_PER_EVENT      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_EVENTS_PER_COUNTDOWN = 3'd6;

    localparam logic [12:0] TICKS_PER_SUB_RESET        = 13'd5000;
    localparam logic [5:0]  SUBS_PER_MINUTE_RESET      = 6'd41;
    localparam logic [5:0]  MINUTES_PER_HOUR_RESET     = 6'd60;
    localparam logic [7:0]  HOURS_PER_BLOCK_RESET      = 8'd200;
    localparam logic [7:0]  BLOCKS_FOR_CHANGE_RESET    = 8'd15;
    localparam logic [12:0] TICKS_PER_EVENT_RESET      = 13'd5000;
    localparam logic [5:0]  EVENTS_PER_COUNTDOWN_RESET = 6'd41;

    typedef struct packed {
        logic [10:0] coarse_count;
        logic [15:0] pulse_count_a;
        logic [15:0] pulse_count_b;
        logic [5:0]  runtime_minutes;
        logic [7:0]  runtime_hours;
        logic [7:0]  runtime_blocks;
        logic        change_due;
        logic        hour_pulse;
        logic        block_pulse;
        logic [7:0]  event_count;
        logic [7:0]  countdown_now;
    } result_t;

endpackage

@@ src/filter_runtime_tick_cascade_core.sv @@
// Tick cascade core: every accepted input transaction is one base tick. The
// tick updates all counter chains (fine and coarse divider, two pulse counters,
// the filter-life chain from sub-minutes up to hour blocks with its sticky
// change-due flag, and the event chain with its 8-bit countdown) and yields one
// result transaction that shows the state after that tick. A tick is accepted
// in every cycle with in_valid high and in_stall low; its result is registered
// in the output entry, or in the skid entry while the output is stalled. The
// state update is a single pass of increments and compares between the counter
// registers and a two-entry result buffer, so a stalled output side absorbs
// one result before in_stall rises. Configuration writes take effect on the
// next tick and are meant to be made only while no tick is in flight.
module filter_runtime_tick_cascade_core #(
    parameter int FINE_DIVIDE = frtc_pkg::FINE_DIVIDE_DEFAULT,
    parameter int COARSE_WRAP = frtc_pkg::COARSE_WRAP_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           cfg_write,
    input  logic [frtc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [frtc_pkg::CFG_DATA_W-1:0]  cfg_data,

    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           pin_low,
    input  logic                           channel_select,
    input  logic                           countdown_enable,
    input  logic                           load_countdown,
    input  logic [7:0]                     countdown_value,

    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [10:0]                    coarse_count,
    output logic [15:0]                    pulse_count_a,
    output logic [15:0]                    pulse_count_b,
    output logic [5:0]                     runtime_minutes,
    output logic [7:0]                     runtime_hours,
    output logic [7:0]                     runtime_blocks,
    output logic                           change_due,
    output logic                           hour_pulse,
    output logic                           block_pulse,
    output logic [7:0]                     event_count,
    output logic [7:0]                     countdown_now
);
    import frtc_pkg::*;

    logic [12:0] ticks_per_sub_reg;
    logic [5:0]  subs_per_minute_reg;
    logic [5:0]  minutes_per_hour_reg;
    logic [7:0]  hours_per_block_reg;
    logic [7:0]  blocks_for_change_reg;
    logic [12:0] ticks_per_event_reg;
    logic [5:0]  events_per_countdown_reg;

    logic [3:0]  fine_divider_reg, fine_divider_next;
    logic [10:0] coarse_counter_reg, coarse_counter_next;
    logic [15:0] count_a_reg, count_a_next;
    logic [15:0] count_b_reg, count_b_next;
    logic [12:0] sub_tick_reg, sub_tick_next;
    logic [5:0]  sub_minute_reg, sub_minute_next;
    logic [5:0]  minute_reg, minute_next;
    logic [7:0]  hour_reg, hour_next;
    logic [7:0]  block_reg, block_next;
    logic        change_reg, change_next;
    logic [12:0] event_tick_reg, event_tick_next;
    logic [5:0]  event_sub_reg, event_sub_next;
    logic [7:0]  event_count_reg, event_count_next;
    logic [7:0]  countdown_reg, countdown_next;

    logic [3:0]  fine_inc;
    logic [11:0] coarse_inc;
    logic [12:0] sub_tick_inc;
    logic [5:0]  sub_minute_inc;
    logic [5:0]  minute_inc;
    logic [7:0]  hour_inc;
    logic [7:0]  block_inc;
    logic [12:0] event_tick_inc;
    logic [5:0]  event_sub_inc;
    logic [7:0]  countdown_base;
    logic        fine_carry, sub_carry, sub_minute_carry, hour_done, block_done;
    logic        event_carry, event_sub_carry;

    result_t     result;
    result_t     out_reg, skid_reg;
    logic        out_valid_reg, skid_valid_reg;
    logic        in_fire;

    assign in_stall = skid_valid_reg;
    assign in_fire  = in_valid && !skid_valid_reg;

    always_comb
    begin
        countdown_base = load_countdown ? countdown_value : countdown_reg;

        fine_inc          = fine_divider_reg + 4'd1;
        fine_carry        = (fine_inc >= 4'(FINE_DIVIDE));
        fine_divider_next = fine_carry ? 4'd0 : fine_inc;

        coarse_inc          = {1'b0, coarse_counter_reg} + 12'd1;
        coarse_counter_next = coarse_counter_reg;
        count_a_next        = count_a_reg;
        count_b_next        = count_b_reg;
        if (fine_carry)
        begin
            coarse_counter_next = (coarse_inc > 12'(COARSE_WRAP)) ? 11'd0 : coarse_inc[10:0];
            if (pin_low && !channel_select)
            begin
                count_a_next = count_a_reg + 16'd1;
            end
            if (pin_low && channel_select)
            begin
                count_b_next = count_b_reg + 16'd1;
            end
        end

        sub_tick_inc  = sub_tick_reg + 13'd1;
        sub_carry     = (sub_tick_inc >= ticks_per_sub_reg);
        sub_tick_next = sub_carry ? 13'd0 : sub_tick_inc;

        sub_minute_inc   = sub_minute_reg + 6'd1;
        sub_minute_carry = sub_carry && (sub_minute_inc >= subs_per_minute_reg);
        sub_minute_next  = !sub_carry ? sub_minute_reg
                         : (sub_minute_carry ? 6'd0 : sub_minute_inc);

        minute_inc  = minute_reg + 6'd1;
        hour_done   = sub_minute_carry && (minute_inc >= minutes_per_hour_reg);
        minute_next = !sub_minute_carry ? minute_reg : (hour_done ? 6'd0 : minute_inc);

        hour_inc   = hour_reg + 8'd1;
        block_done = hour_done && (hour_inc >= hours_per_block_reg);
        hour_next  = !hour_done ? hour_reg : (block_done ? 8'd0 : hour_inc);

        block_inc   = block_reg + 8'd1;
        block_next  = block_done ? block_inc : block_reg;
        change_next = change_reg || (block_done && (block_inc >= blocks_for_change_reg));

        event_tick_inc   = event_tick_reg + 13'd1;
        event_carry      = (event_tick_inc >= ticks_per_event_reg);
        event_tick_next  = event_carry ? 13'd0 : event_tick_inc;
        event_count_next = event_carry ? event_count_reg + 8'd1 : event_count_reg;

        event_sub_inc   = event_sub_reg + 6'd1;
        event_sub_carry = event_carry && (event_sub_inc >= events_per_countdown_reg);
        event_sub_next  = !event_carry ? event_sub_reg
                        : (event_sub_carry ? 6'd0 : event_sub_inc);
        countdown_next  = (event_sub_carry && countdown_enable) ? countdown_base - 8'd1
                        : countdown_base;

        result.coarse_count    = coarse_counter_next;
        result.pulse_count_a   = count_a_next;
        result.pulse_count_b   = count_b_next;
        result.runtime_minutes = minute_next;
        result.runtime_hours   = hour_next;
        result.runtime_blocks  = block_next;
        result.change_due      = change_next;
        result.hour_pulse      = hour_done;
        result.block_pulse     = block_done;
        result.event_count     = event_count_next;
        result.countdown_now   = countdown_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_per_sub_reg        <= TICKS_PER_SUB_RESET;
            subs_per_minute_reg      <= SUBS_PER_MINUTE_RESET;
            minutes_per_hour_reg     <= MINUTES_PER_HOUR_RESET;
            hours_per_block_reg      <= HOURS_PER_BLOCK_RESET;
            blocks_for_change_reg    <= BLOCKS_FOR_CHANGE_RESET;
            ticks_per_event_reg      <= TICKS_PER_EVENT_RESET;
            events_per_countdown_reg <= EVENTS_PER_COUNTDOWN_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_TICKS_PER_SUB:        ticks_per_sub_reg        <= cfg_data;
                REG_SUBS_PER_MINUTE:      subs_per_minute_reg      <= cfg_data[5:0];
                REG_MINUTES_PER_HOUR:     minutes_per_hour_reg     <= cfg_data[5:0];
                REG_HOURS_PER_BLOCK:      hours_per_block_reg      <= cfg_data[7:0];
                REG_BLOCKS_FOR_CHANGE:    blocks_for_change_reg    <= cfg_data[7:0];
                REG_TICKS_PER_EVENT:      ticks_per_event_reg      <= cfg_data;
                REG_EVENTS_PER_COUNTDOWN: events_per_countdown_reg <= cfg_data[5:0];
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fine_divider_reg   <= '0;
            coarse_counter_reg <= '0;
            count_a_reg        <= '0;
            count_b_reg        <= '0;
            sub_tick_reg       <= '0;
            sub_minute_reg     <= '0;
            minute_reg         <= '0;
            hour_reg           <= '0;
            block_reg          <= '0;
            change_reg         <= 1'b0;
            event_tick_reg     <= '0;
            event_sub_reg      <= '0;
            event_count_reg    <= '0;
            countdown_reg      <= '0;
        end
        else if (in_fire)
        begin
            fine_divider_reg   <= fine_divider_next;
            coarse_counter_reg <= coarse_counter_next;
            count_a_reg        <= count_a_next;
            count_b_reg        <= count_b_next;
            sub_tick_reg       <= sub_tick_next;
            sub_minute_reg     <= sub_minute_next;
            minute_reg         <= minute_next;
            hour_reg           <= hour_next;
            block_reg          <= block_next;
            change_reg         <= change_next;
            event_tick_reg     <= event_tick_next;
            event_sub_reg      <= event_sub_next;
            event_count_reg    <= event_count_next;
            countdown_reg      <= countdown_next;
        end
    end

    // The skid entry only fills while the output entry is held by a stall.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_fire;
            end
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (in_fire)
            begin
                out_reg <= result;
            end
        end
        else if (in_fire)
        begin
            skid_reg <= result;
        end
    end

    assign out_valid       = out_valid_reg;
    assign coarse_count    = out_reg.coarse_count;
    assign pulse_count_a   = out_reg.pulse_count_a;
    assign pulse_count_b   = out_reg.pulse_count_b;
    assign runtime_minutes = out_reg.runtime_minutes;
    assign runtime_hours   = out_reg.runtime_hours;
    assign runtime_blocks  = out_reg.runtime_blocks;
    assign change_due      = out_reg.change_due;
    assign hour_pulse      = out_reg.hour_pulse;
    assign block_pulse     = out_reg.block_pulse;
    assign event_count     = out_reg.event_count;
    assign countdown_now   = out_reg.countdown_now;

endmodule

@@ src/frtc_checker.sv @@
`include "filter_runtime_tick_cascade_core_macros.svh"

module frtc_checker #(
    parameter int COARSE_WRAP = frtc_pkg::COARSE_WRAP_DEFAULT
) (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [10:0] coarse_count,
    input logic        change_due,
    input logic        hour_pulse,
    input logic        block_pulse
);
    import frtc_pkg::*;

    `FRTC_ASSERT(a_stall_hold, out_valid && out_stall |=> out_valid && $stable(coarse_count) && $stable(change_due), "stalled result changed")
    `FRTC_ASSERT(a_block_has_hour, out_valid && block_pulse |-> hour_pulse, "block pulse without hour pulse")
    `FRTC_ASSERT(a_change_sticky, out_valid && !out_stall && change_due |=> !out_valid || change_due, "change due flag cleared")
    `FRTC_ASSERT(a_coarse_range, out_valid |-> coarse_count <= 11'(COARSE_WRAP), "coarse count beyond wrap")
    `FRTC_ASSERT_ALWAYS(a_reset_idle, !rst_n |-> !out_valid, "result valid during reset")

endmodule

bind filter_runtime_tick_cascade_core frtc_checker #(
    .COARSE_WRAP(COARSE_WRAP)
) u_frtc_checker (
    .clk(clk),
    .rst_n(rst_n),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .coarse_count(coarse_count),
    .change_due(change_due),
    .hour_pulse(hour_pulse),
    .block_pulse(block_pulse)
);
